// ===== sv/pee_pkg.sv =====
// ----------------------------------------------------------------------------
// pee_pkg
// shared types and codes for the prefix expression evaluator
// ----------------------------------------------------------------------------
package pee_pkg;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_MUL   = 8'h2a;
	localparam logic [7:0] CH_DIV   = 8'h2f;
	localparam logic [7:0] CH_POW   = 8'h5e;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_UNDER   = 3'd1;
	localparam logic [2:0] ERR_DIVZERO = 3'd2;
	localparam logic [2:0] ERR_OVER    = 3'd3;
	localparam logic [2:0] ERR_EMPTY   = 3'd4;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_POW,
		OP_NOP
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_EXEC,
		ST_WAIT,
		ST_PUSH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_sym;
		logic rd_top;
		logic rd_next;
		logic cap_a;
		logic cap_b;
		logic start;
		logic push_digit;
		logic push_res;
		logic do_pop2;
		logic under;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic is_digit;
		logic is_final;
		logic lt2;
		logic busy;
		logic done;
		logic out_taken;
	} sts_t;

endpackage

// ===== sv/prefix_expression_evaluator.sv =====
// one word per symbol; power runs a square-and-multiply pass per bit of the exponent
// in the arithmetic unit; the final symbol adds a read of the stack top before output.
// arst_n clears the stack count, sticky error and controller; stack memory is not cleared.
// ----------------------------------------------------------------------------
// prefix_expression_evaluator
// stack based evaluator of reversed prefix expressions
// ----------------------------------------------------------------------------
module prefix_expression_evaluator #(
	parameter int STACK_DEPTH = 64,
	parameter int VALUE_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // symbol
	input  logic        s_tlast,  // final_symbol
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // value[31:0], status[34:32], zero fill
);

	pee_pkg::cmd_t cmd;
	pee_pkg::sts_t sts;
	logic [31:0] value;
	logic [2:0] status;

	pee_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .sts(sts), .cmd(cmd)
	);

	pee_dp #(.STACK_DEPTH(STACK_DEPTH), .VALUE_BITS(VALUE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .symbol(s_tdata), .final_symbol(s_tlast),
		.out_ready(m_tready), .cmd(cmd), .sts(sts), .value(value), .status(status)
	);

	assign m_tdata = {5'b0, status, value};

`ifndef NO_ASSERTIONS
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("accept while output pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("output dropped");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[34:32] <= 3'd4) else $error("bad status");
`endif

endmodule

// ===== sv/pee_ctrl.sv =====
// ----------------------------------------------------------------------------
// pee_ctrl
// sequencer for stack reads, arithmetic and result output
// ----------------------------------------------------------------------------
module pee_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  pee_pkg::sts_t  sts,
	output pee_pkg::cmd_t  cmd
);

	pee_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pee_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			pee_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_sym = 1'b1;
					state_d = pee_pkg::ST_RD_A;
				end
			end
			pee_pkg::ST_RD_A: begin
				if (sts.is_digit) begin
					cmd.push_digit = 1'b1;
					state_d = sts.is_final ? pee_pkg::ST_PUSH : pee_pkg::ST_IDLE;
				end else if (sts.lt2) begin
					cmd.under = 1'b1;
					state_d = sts.is_final ? pee_pkg::ST_PUSH : pee_pkg::ST_IDLE;
				end else begin
					cmd.rd_top = 1'b1;
					state_d = pee_pkg::ST_RD_B;
				end
			end
			pee_pkg::ST_RD_B: begin
				cmd.cap_a = 1'b1;
				cmd.rd_next = 1'b1;
				state_d = pee_pkg::ST_EXEC;
			end
			pee_pkg::ST_EXEC: begin
				cmd.cap_b = 1'b1;
				cmd.do_pop2 = 1'b1;
				state_d = pee_pkg::ST_WAIT;
			end
			pee_pkg::ST_WAIT: begin
				if (!sts.busy && !sts.done) cmd.start = 1'b1;
				if (sts.done) begin
					cmd.push_res = 1'b1;
					state_d = sts.is_final ? pee_pkg::ST_PUSH : pee_pkg::ST_IDLE;
				end
			end
			pee_pkg::ST_PUSH: begin
				cmd.rd_top = 1'b1;
				state_d = pee_pkg::ST_OUT;
			end
			pee_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (sts.out_taken) begin
					cmd.clear = 1'b1;
					state_d = pee_pkg::ST_IDLE;
				end
			end
			default: state_d = pee_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== sv/pee_alu.sv =====
// ----------------------------------------------------------------------------
// pee_alu
// multicycle arithmetic unit: add, subtract, multiply, divide, power
// ----------------------------------------------------------------------------
module pee_alu #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  pee_pkg::op_t          op,
	input  logic [VALUE_BITS-1:0] a,
	input  logic [VALUE_BITS-1:0] b,
	output logic                  busy,
	output logic                  done,
	output logic                  push,
	output logic                  divzero,
	output logic [VALUE_BITS-1:0] res
);

	localparam int CW = $clog2(VALUE_BITS + 1);
	localparam logic [CW-1:0] LAST = CW'(VALUE_BITS - 1);

	logic [VALUE_BITS-1:0] acc_q, sq_q, ex_q, rem_q, den_q, quo_q;
	logic [CW-1:0] cnt_q;
	logic neg_q, mul_q, sqs_q, busy_q, done_q;
	pee_pkg::op_t op_q;
	logic [VALUE_BITS:0] trial;
	logic [VALUE_BITS-1:0] rem_sh;
	logic [VALUE_BITS-1:0] ma, mb;

	assign ma = a[VALUE_BITS-1] ? -a : a;
	assign mb = b[VALUE_BITS-1] ? -b : b;
	assign rem_sh = {rem_q[VALUE_BITS-2:0], quo_q[VALUE_BITS-1]};
	assign trial = {1'b0, rem_sh} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				op_q <= op;
				cnt_q <= '0;
				push <= (op != pee_pkg::OP_NOP);
				divzero <= 1'b0;
				mul_q <= 1'b0;
				sqs_q <= 1'b0;
				unique case (op)
					pee_pkg::OP_ADD: begin acc_q <= a + b; busy_q <= 1'b0; done_q <= 1'b1; end
					pee_pkg::OP_SUB: begin acc_q <= a - b; busy_q <= 1'b0; done_q <= 1'b1; end
					pee_pkg::OP_MUL: begin
						acc_q <= VALUE_BITS'(1);
						sq_q <= a;
						ex_q <= b;
						cnt_q <= LAST;
					end
					pee_pkg::OP_DIV: begin
						neg_q <= a[VALUE_BITS-1] ^ b[VALUE_BITS-1];
						rem_q <= '0;
						quo_q <= ma;
						den_q <= mb;
						if (b == '0) begin
							divzero <= 1'b1;
							acc_q <= '0;
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					pee_pkg::OP_POW: begin
						acc_q <= VALUE_BITS'(1);
						sq_q <= a;
						ex_q <= b;
						if (b[VALUE_BITS-1]) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
							if (a == VALUE_BITS'(1)) acc_q <= VALUE_BITS'(1);
							else if (a == '1) acc_q <= b[0] ? '1 : VALUE_BITS'(1);
							else begin
								acc_q <= '0;
								divzero <= (a == '0);
							end
						end
					end
					default: begin busy_q <= 1'b0; done_q <= 1'b1; end
				endcase
			end else if (busy_q) begin
				unique case (op_q)
					pee_pkg::OP_MUL: begin
						// shift and add, one multiplier bit a cycle
						if (ex_q[0]) acc_q <= (cnt_q == LAST && !mul_q) ? sq_q : acc_q + sq_q;
						if (!ex_q[0] && !mul_q) acc_q <= '0;
						mul_q <= 1'b1;
						sq_q <= {sq_q[VALUE_BITS-2:0], 1'b0};
						ex_q <= {1'b0, ex_q[VALUE_BITS-1:1]};
						cnt_q <= cnt_q - CW'(1);
						if (cnt_q == '0) begin busy_q <= 1'b0; done_q <= 1'b1; end
					end
					pee_pkg::OP_DIV: begin
						if (!trial[VALUE_BITS]) rem_q <= trial[VALUE_BITS-1:0];
						else rem_q <= rem_sh;
						quo_q <= {quo_q[VALUE_BITS-2:0], ~trial[VALUE_BITS]};
						cnt_q <= cnt_q + CW'(1);
						if (cnt_q == LAST) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
							acc_q <= neg_q ? -{quo_q[VALUE_BITS-2:0], ~trial[VALUE_BITS]}
								: {quo_q[VALUE_BITS-2:0], ~trial[VALUE_BITS]};
						end
					end
					pee_pkg::OP_POW: begin
						// one multiply step and one squaring step per exponent bit, combinational multiplies
						if (!sqs_q) begin
							if (ex_q[0]) acc_q <= VALUE_BITS'(acc_q * sq_q);
							sqs_q <= 1'b1;
						end else begin
							sq_q <= VALUE_BITS'(sq_q * sq_q);
							ex_q <= {1'b0, ex_q[VALUE_BITS-1:1]};
							sqs_q <= 1'b0;
							cnt_q <= cnt_q + CW'(1);
							if (cnt_q == LAST) begin busy_q <= 1'b0; done_q <= 1'b1; end
						end
					end
					default: begin busy_q <= 1'b0; done_q <= 1'b1; end
				endcase
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign res = acc_q;

endmodule

// ===== sv/pee_dp.sv =====
// ----------------------------------------------------------------------------
// pee_dp
// operand stack memory, stack counter, sticky error and arithmetic
// ----------------------------------------------------------------------------
module pee_dp #(
	parameter int STACK_DEPTH = 64,
	parameter int VALUE_BITS  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            symbol,
	input  logic                  final_symbol,
	input  logic                  out_ready,
	input  pee_pkg::cmd_t         cmd,
	output pee_pkg::sts_t         sts,
	output logic [31:0]           value,
	output logic [2:0]            status
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [VALUE_BITS-1:0] mem [STACK_DEPTH];
	logic [VALUE_BITS-1:0] rd_q, a_q, b_q, alu_res, wdata;
	logic [CW-1:0] cnt_q;
	logic [2:0] err_q;
	logic [7:0] sym_q;
	logic fin_q, is_digit, we, alu_push, alu_divz, alu_busy, alu_done;
	logic [AW-1:0] raddr;
	pee_pkg::op_t op;

	assign is_digit = (sym_q >= pee_pkg::CH_0) && (sym_q <= pee_pkg::CH_9);

	always_comb begin
		unique case (sym_q)
			pee_pkg::CH_PLUS:  op = pee_pkg::OP_ADD;
			pee_pkg::CH_MINUS: op = pee_pkg::OP_SUB;
			pee_pkg::CH_MUL:   op = pee_pkg::OP_MUL;
			pee_pkg::CH_DIV:   op = pee_pkg::OP_DIV;
			pee_pkg::CH_POW:   op = pee_pkg::OP_POW;
			default:           op = pee_pkg::OP_NOP;
		endcase
	end

	assign raddr = cmd.rd_next ? AW'(cnt_q - CW'(2)) : AW'(cnt_q - CW'(1));
	assign we = (cmd.push_digit || (cmd.push_res && alu_push)) && (cnt_q != CW'(STACK_DEPTH));
	assign wdata = cmd.push_digit ? VALUE_BITS'(sym_q - pee_pkg::CH_0) : alu_res;

	always_ff @(posedge clk) begin
		if (we) mem[AW'(cnt_q)] <= wdata;
		rd_q <= mem[raddr];
		if (cmd.load_sym) begin
			sym_q <= symbol;
			fin_q <= final_symbol;
		end
		if (cmd.cap_a) a_q <= rd_q;
		if (cmd.cap_b) b_q <= rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			err_q <= pee_pkg::ERR_NONE;
		end else if (cmd.clear) begin
			cnt_q <= '0;
			err_q <= pee_pkg::ERR_NONE;
		end else begin
			if (cmd.under) begin
				cnt_q <= '0;
				if (err_q == pee_pkg::ERR_NONE) err_q <= pee_pkg::ERR_UNDER;
			end
			if (cmd.do_pop2) cnt_q <= cnt_q - CW'(2);
			if (we) cnt_q <= cnt_q + CW'(1);
			if (cmd.push_res && alu_divz && err_q == pee_pkg::ERR_NONE)
				err_q <= pee_pkg::ERR_DIVZERO;
			else if ((cmd.push_digit || (cmd.push_res && alu_push)) && !we
				&& err_q == pee_pkg::ERR_NONE)
				err_q <= pee_pkg::ERR_OVER;
		end
	end

	pee_alu #(.VALUE_BITS(VALUE_BITS)) u_alu (
		.clk(clk), .arst_n(arst_n), .start(cmd.start), .op(op), .a(a_q), .b(b_q),
		.busy(alu_busy), .done(alu_done), .push(alu_push), .divzero(alu_divz), .res(alu_res)
	);

	assign sts.is_digit = is_digit;
	assign sts.is_final = fin_q;
	assign sts.lt2 = (cnt_q < CW'(2));
	assign sts.busy = alu_busy;
	assign sts.done = alu_done;
	assign sts.out_taken = out_ready;

	always_comb begin
		if (cnt_q == '0) value = '0;
		else value = 32'(rd_q);
		if (err_q != pee_pkg::ERR_NONE) status = err_q;
		else if (cnt_q == '0) status = pee_pkg::ERR_EMPTY;
		else status = pee_pkg::ERR_NONE;
	end

endmodule

// ===== dv/prefix_expression_evaluator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_expression_evaluator_tb
// streams reversed prefix expressions into the evaluator, predicts the top
// value and status of each expression and compares every output word
// ----------------------------------------------------------------------------
module prefix_expression_evaluator_tb;

	localparam int DEPTH = 64;
	localparam longint LIMIT = 3000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	typedef struct packed {
		logic [7:0] sym;
		logic       last;
	} sym_word_t;

	typedef struct packed {
		logic [31:0] value;
		logic [2:0]  status;
	} eval_result_t;

	sym_word_t    pending_syms[$];
	eval_result_t expected_results[$];

	logic [31:0] eval_stack[DEPTH];
	int          eval_depth;
	logic [2:0]  eval_error;

	int     errors;
	int     results_seen;
	int     syms_sent;
	int     feed_gap;
	int     drain_gap;
	int     hold_off;
	longint cycles;

	prefix_expression_evaluator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #4 clk = ~clk;

	function automatic void note_error(logic [2:0] code);
		if (eval_error == pee_pkg::ERR_NONE) eval_error = code;
	endfunction

	function automatic logic [31:0] int_pow(logic [31:0] base, logic [31:0] ex);
		logic [31:0] acc;
		logic [31:0] sq;
		acc = 32'd1;
		sq = base;
		if (ex[31]) begin
			if (base == 32'd1) return 32'd1;
			if (base == '1) return ex[0] ? '1 : 32'd1;
			if (base == 32'd0) note_error(pee_pkg::ERR_DIVZERO);
			return 32'd0;
		end
		for (int i = 0; i < 32; i++) begin
			if (ex[i]) acc = acc * sq;
			sq = sq * sq;
		end
		return acc;
	endfunction

	function automatic void push_value(logic [31:0] v);
		if (eval_depth >= DEPTH) begin
			note_error(pee_pkg::ERR_OVER);
		end else begin
			eval_stack[eval_depth] = v;
			eval_depth++;
		end
	endfunction

	function automatic void eval_symbol(sym_word_t w);
		logic [31:0]  a;
		logic [31:0]  b;
		logic [31:0]  r;
		eval_result_t res;
		if (w.sym >= pee_pkg::CH_0 && w.sym <= pee_pkg::CH_9) begin
			push_value(32'(w.sym - pee_pkg::CH_0));
		end else if (eval_depth < 2) begin
			note_error(pee_pkg::ERR_UNDER);
			eval_depth = 0;
		end else begin
			a = eval_stack[eval_depth - 1];
			b = eval_stack[eval_depth - 2];
			eval_depth -= 2;
			case (w.sym)
				pee_pkg::CH_PLUS: push_value(a + b);
				pee_pkg::CH_MINUS: push_value(a - b);
				pee_pkg::CH_MUL: push_value(a * b);
				pee_pkg::CH_DIV: begin
					if (b == 0) begin
						note_error(pee_pkg::ERR_DIVZERO);
						r = 0;
					end else begin
						// wide quotient so the most negative value over -1 wraps to itself
						r = 32'(longint'($signed(a)) / longint'($signed(b)));
					end
					push_value(r);
				end
				pee_pkg::CH_POW: push_value(int_pow(a, b));
				default: ;
			endcase
		end
		if (w.last) begin
			res.value = eval_depth > 0 ? eval_stack[eval_depth - 1] : 32'd0;
			res.status = eval_error != pee_pkg::ERR_NONE ? eval_error :
				(eval_depth == 0 ? pee_pkg::ERR_EMPTY : pee_pkg::ERR_NONE);
			expected_results.push_back(res);
			eval_depth = 0;
			eval_error = pee_pkg::ERR_NONE;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [7:0] rand_digit();
		return pee_pkg::CH_0 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_op();
		case ($urandom_range(0, 4))
			0: return pee_pkg::CH_PLUS;
			1: return pee_pkg::CH_MINUS;
			2: return pee_pkg::CH_MUL;
			3: return pee_pkg::CH_DIV;
			default: return pee_pkg::CH_POW;
		endcase
	endfunction

	task automatic queue_sym(logic [7:0] s, logic l);
		sym_word_t w;
		w.sym = s;
		w.last = l;
		pending_syms.push_back(w);
	endtask

	task automatic queue_string(string s);
		for (int i = s.len() - 1; i >= 0; i--) queue_sym(s[i], i == 0);
	endtask

	// well formed reversed prefix expression with n operators
	task automatic queue_random_expr(int n_ops);
		logic [7:0] syms[$];
		int need;
		syms.push_back(rand_digit());
		need = n_ops;
		while (need > 0) begin
			syms.push_back(rand_digit());
			syms.push_back(rand_op());
			need--;
		end
		// syms in feed order: digit, then (digit, op) pairs
		for (int i = 0; i < syms.size(); i++) queue_sym(syms[i], i == syms.size() - 1);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			feed_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				eval_symbol({s_tdata, s_tlast});
				syms_sent <= syms_sent + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (feed_gap > 0) begin
					s_tvalid <= 1'b0;
					feed_gap <= feed_gap - 1;
				end else if (pending_syms.size() > 0) begin
					{s_tdata, s_tlast} <= pending_syms.pop_front();
					s_tvalid <= 1'b1;
					feed_gap <= pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		eval_result_t got;
		eval_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			drain_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.value = m_tdata[31:0];
				got.status = m_tdata[34:32];
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					$error("output word with nothing expected: %h", m_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got.value !== want.value) begin
						$error("value expected %h actual %h", want.value, got.value);
						errors++;
					end
					if (got.status !== want.status) begin
						$error("status expected %0d actual %0d", want.status, got.status);
						errors++;
					end
				end
			end
			if (hold_off > 0) begin
				m_tready <= 1'b0;
			end else if (drain_gap > 0) begin
				m_tready <= 1'b0;
				drain_gap <= drain_gap - 1;
			end else begin
				m_tready <= 1'b1;
				drain_gap <= pick_gap();
			end
		end
	end

	// long receiver stall while symbols are still queued
	initial begin
		hold_off = 0;
		wait (syms_sent > 300);
		hold_off = 1;
		repeat (3000) @(posedge clk);
		hold_off = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout with %0d words pending", expected_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		errors = 0;
		results_seen = 0;
		syms_sent = 0;
		cycles = 0;
		eval_depth = 0;
		eval_error = pee_pkg::ERR_NONE;
		// directed: extremes, each operator, special cases
		queue_string("+34");
		queue_string("-27");
		queue_string("*99");
		queue_string("/73");
		queue_string("/-0273");
		queue_string("/50");
		queue_string("^23");
		queue_string("^20");
		queue_string("^0-12");
		queue_string("^1-12");
		queue_string("^-01-12");
		queue_string("^-01-13");
		queue_string("^5-12");
		queue_string("+3");
		queue_string("+");
		queue_sym(8'hff, 1'b1);
		queue_sym(8'h00, 1'b1);
		queue_string("?12");
		queue_string("^9^9^99");
		queue_string("/-^^9999^^9999-01");
		for (int i = 0; i < 70; i++) queue_sym(rand_digit(), 1'b0);
		queue_sym(pee_pkg::CH_PLUS, 1'b1);
		queue_string("+*34");
		wait (pending_syms.size() == 0);
		// random: mostly well formed expressions, some noise
		while (pending_syms.size() + syms_sent < 1350) begin
			if ($urandom_range(0, 9) < 8) begin
				queue_random_expr($urandom_range(0, 6));
			end else begin
				repeat ($urandom_range(1, 6))
					queue_sym(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
				queue_sym(rand_digit(), 1'b1);
			end
		end
		wait (pending_syms.size() == 0 && !s_tvalid);
		wait (expected_results.size() == 0);
		repeat (200) @(posedge clk);
		$display("sent %0d symbols, checked %0d results", syms_sent, results_seen);
		$display("covered all operators, stack faults, divide by zero and unknown symbols");
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

endmodule
